[rtl/core/rpc_pkg.sv]
// rpc_pkg: shared types, constants and helpers of the rectangular/polar converter
`default_nettype none

package rpc_pkg;

    localparam int ITERATIONS  = 16;
    localparam int COORD_WIDTH = 16;
    localparam int TABLE_LEN   = 24;
    localparam int STAGES      = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    localparam int ITER_W      = $clog2(TABLE_LEN);
    localparam int GUARD       = 12;

    localparam int DW = 32;
    localparam int ZW = 28;

    localparam logic signed [30:0]   K_Q30        = 31'sd652032874;
    localparam logic signed [ZW-1:0] PI_Z         = 28'sd52707179;
    localparam logic signed [ZW-1:0] HALF_PI_Z    = 28'sd26353589;
    localparam logic signed [16:0]   PI_Q13       = 17'sd25736;
    localparam logic signed [16:0]   TWO_PI_Q13   = 17'sd51472;

    localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam longint COORD_MIN = -COORD_MAX - 64'sd1;

    localparam logic signed [ZW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2
    };

    typedef logic [ITER_W-1:0] t_iter;

    typedef struct packed {
        logic                 action;
        logic                 zero;
        logic signed [16:0]   first;
        logic signed [15:0]   second;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_item;

    function automatic logic [15:0] sat_coord(input logic signed [DW-1:0] v);
        logic [15:0] res;
        if (longint'(v) > COORD_MAX) begin
            res = 16'(COORD_MAX);
        end else if (longint'(v) < COORD_MIN) begin
            res = 16'(COORD_MIN);
        end else begin
            res = 16'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/rpc_pre.sv]
// rpc_pre: operand preparation, angle reduction and gain pre-scaling ahead of the cordic stages
`default_nettype none

module rpc_pre (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic                  i_action,
    input  logic signed [16:0]    i_first_operand,
    input  logic signed [15:0]    i_second_operand,
    output logic                  o_valid,
    output rpc_pkg::t_item        o_item
);

    logic                         r_p1_valid;
    rpc_pkg::t_item               r_p1;
    logic signed [17:0]           r_p1_r;
    logic                         r_p2_valid;
    rpc_pkg::t_item               r_p2;
    logic signed [47:0]           r_p2_prod;
    logic                         r_p3_valid;
    rpc_pkg::t_item               r_p3;

    rpc_pkg::t_item               n_p1;
    logic signed [17:0]           n_p1_r;
    rpc_pkg::t_item               n_p3;
    logic signed [rpc_pkg::DW-1:0] x0;
    logic signed [rpc_pkg::DW-1:0] y0;
    logic signed [16:0]           a_ext;
    logic signed [16:0]           a_red;
    logic signed [rpc_pkg::ZW-1:0] z_a;
    logic signed [rpc_pkg::DW-1:0] x_round;

    always_comb begin
        x0     = rpc_pkg::DW'(i_first_operand) <<< rpc_pkg::GUARD;
        y0     = rpc_pkg::DW'(i_second_operand) <<< rpc_pkg::GUARD;
        a_ext  = 17'(i_second_operand);
        n_p1_r = 18'(i_first_operand);

        n_p1        = '0;
        n_p1.action = i_action;
        n_p1.zero   = (i_first_operand == 17'sd0) && (i_second_operand == 16'sd0);
        n_p1.first  = i_first_operand;
        n_p1.second = i_second_operand;

        if (a_ext > rpc_pkg::PI_Q13) begin
            a_red = a_ext - rpc_pkg::TWO_PI_Q13;
        end else if (a_ext < -rpc_pkg::PI_Q13) begin
            a_red = a_ext + rpc_pkg::TWO_PI_Q13;
        end else begin
            a_red = a_ext;
        end
        z_a = rpc_pkg::ZW'(a_red) <<< 11;

        if (i_action) begin
            if (z_a > rpc_pkg::HALF_PI_Z) begin
                n_p1_r = -18'(i_first_operand);
                n_p1.z = z_a - rpc_pkg::PI_Z;
            end else if (z_a < -rpc_pkg::HALF_PI_Z) begin
                n_p1_r = -18'(i_first_operand);
                n_p1.z = z_a + rpc_pkg::PI_Z;
            end else begin
                n_p1.z = z_a;
            end
        end else if (i_first_operand < 17'sd0) begin
            n_p1.x = -x0;
            n_p1.y = -y0;
            n_p1.z = (i_second_operand >= 16'sd0) ? rpc_pkg::PI_Z : -rpc_pkg::PI_Z;
        end else begin
            n_p1.x = x0;
            n_p1.y = y0;
        end

        x_round = rpc_pkg::DW'((r_p2_prod + (48'sd1 <<< 17)) >>> 18);

        n_p3 = r_p2;
        if (r_p2.action) begin
            n_p3.x = x_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (i_en) begin
            r_p1_valid <= i_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1      <= n_p1;
            r_p1_r    <= n_p1_r;
            r_p2      <= r_p1;
            r_p2_prod <= 48'(r_p1_r) * 48'(rpc_pkg::K_Q30);
            r_p3      <= n_p3;
        end
    end

    assign o_valid = r_p3_valid;
    assign o_item  = r_p3;

endmodule

`default_nettype wire

[rtl/core/rpc_stage.sv]
// rpc_stage: one registered cordic micro-rotation, vectoring or rotation by item action
`default_nettype none

module rpc_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rpc_pkg::t_item i_item,
    input  rpc_pkg::t_iter i_iter,
    output logic           o_valid,
    output rpc_pkg::t_item o_item
);

    logic                          r_valid;
    rpc_pkg::t_item                r_item;
    rpc_pkg::t_item                n_item;
    logic                          ccw;
    logic signed [rpc_pkg::DW-1:0] x_sh;
    logic signed [rpc_pkg::DW-1:0] y_sh;
    logic signed [rpc_pkg::ZW-1:0] atan_val;

    always_comb begin
        ccw      = i_item.action ? !i_item.z[rpc_pkg::ZW-1] : i_item.y[rpc_pkg::DW-1];
        x_sh     = i_item.x >>> i_iter;
        y_sh     = i_item.y >>> i_iter;
        atan_val = rpc_pkg::ATAN_TAB[i_iter];
        n_item   = i_item;
        if (ccw) begin
            n_item.x = i_item.x - y_sh;
            n_item.y = i_item.y + x_sh;
            n_item.z = i_item.z - atan_val;
        end else begin
            n_item.x = i_item.x + y_sh;
            n_item.y = i_item.y - x_sh;
            n_item.z = i_item.z + atan_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[rtl/core/rpc_post.sv]
// rpc_post: gain correction, rounding and saturation of cordic results
`default_nettype none

module rpc_post (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  rpc_pkg::t_item     i_item,
    output logic               o_valid,
    output logic signed [15:0] o_x_out,
    output logic signed [15:0] o_y_out,
    output logic signed [16:0] o_magnitude,
    output logic signed [15:0] o_angle
);

    logic                          r_q1_valid;
    logic                          r_q1_action;
    logic                          r_q1_zero;
    logic signed [63:0]            r_q1_prod;
    logic [15:0]                   r_q1_x;
    logic [15:0]                   r_q1_y;
    logic signed [16:0]            r_q1_mag;
    logic signed [15:0]            r_q1_ang;
    logic                          r_q2_valid;
    logic signed [15:0]            r_q2_x;
    logic signed [15:0]            r_q2_y;
    logic signed [16:0]            r_q2_mag;
    logic signed [15:0]            r_q2_ang;

    logic [15:0]                   n_q1_x;
    logic [15:0]                   n_q1_y;
    logic signed [15:0]            n_q1_ang;
    logic signed [16:0]            n_q2_mag;
    logic signed [rpc_pkg::DW-1:0] x_rnd;
    logic signed [rpc_pkg::DW-1:0] y_rnd;
    logic signed [rpc_pkg::ZW-1:0] z_rnd;
    logic signed [63:0]            m_rnd;

    always_comb begin
        x_rnd = (i_item.x + 32'sd2048) >>> rpc_pkg::GUARD;
        y_rnd = (i_item.y + 32'sd2048) >>> rpc_pkg::GUARD;
        z_rnd = (i_item.z + 28'sd1024) >>> 11;
        if (i_item.action) begin
            n_q1_x   = rpc_pkg::sat_coord(x_rnd);
            n_q1_y   = rpc_pkg::sat_coord(y_rnd);
            n_q1_ang = i_item.second;
        end else begin
            n_q1_x = rpc_pkg::sat_coord(rpc_pkg::DW'(i_item.first));
            n_q1_y = rpc_pkg::sat_coord(rpc_pkg::DW'(i_item.second));
            if (i_item.zero) begin
                n_q1_ang = 16'sd0;
            end else if (z_rnd > 28'sd32767) begin
                n_q1_ang = 16'sd32767;
            end else if (z_rnd < -28'sd32768) begin
                n_q1_ang = -16'sd32768;
            end else begin
                n_q1_ang = 16'(z_rnd);
            end
        end

        m_rnd = (r_q1_prod + (64'sd1 <<< 41)) >>> 42;
        if (r_q1_action) begin
            n_q2_mag = r_q1_mag;
        end else if (r_q1_zero || (m_rnd < 64'sd0)) begin
            n_q2_mag = 17'sd0;
        end else if (m_rnd > 64'sd65535) begin
            n_q2_mag = 17'sd65535;
        end else begin
            n_q2_mag = 17'(m_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_valid <= 1'b0;
            r_q2_valid <= 1'b0;
        end else if (i_en) begin
            r_q1_valid <= i_valid;
            r_q2_valid <= r_q1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1_action <= i_item.action;
            r_q1_zero   <= i_item.zero;
            r_q1_prod   <= 64'(i_item.x) * 64'(rpc_pkg::K_Q30);
            r_q1_x      <= n_q1_x;
            r_q1_y      <= n_q1_y;
            r_q1_mag    <= i_item.first;
            r_q1_ang    <= n_q1_ang;
            r_q2_x      <= r_q1_x;
            r_q2_y      <= r_q1_y;
            r_q2_mag    <= n_q2_mag;
            r_q2_ang    <= r_q1_ang;
        end
    end

    assign o_valid     = r_q2_valid;
    assign o_x_out     = r_q2_x;
    assign o_y_out     = r_q2_y;
    assign o_magnitude = r_q2_mag;
    assign o_angle     = r_q2_ang;

endmodule

`default_nettype wire

[rtl/core/rect_polar_converter_core.sv]
// rect_polar_converter_core: pipelined cordic rectangular/polar converter top level
//
// input channel: i_valid with i_action, i_first_operand, i_second_operand; o_stall
// back to the sender. a transfer happens when i_valid is high and o_stall is low.
// action 0 takes x, y and returns magnitude and atan2 angle (q3.13 rad); action 1
// takes radius and q3.13 angle and returns x, y. every result carries all four.
// output channel: o_valid with o_x_out, o_y_out, o_magnitude, o_angle; i_stall
// from the receiver. a transfer happens when o_valid is high and i_stall is low.
// an input transfer reaches o_valid through three preparation stages, one stage per
// cordic iteration (16) and two correction stages.
// throughput is one item per cycle while the receiver does not stall.
// when the receiver stalls, the pending result moves into a one-entry skid
// register as the pipeline advances; with the skid register full, o_stall is
// raised and the whole pipeline holds until it drains.
// reset (synchronous, active low) clears all valid bits and the skid full flag.
`default_nettype none

module rect_polar_converter_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic signed [16:0] i_first_operand,
    input  logic signed [15:0] i_second_operand,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_x_out,
    output logic signed [15:0] o_y_out,
    output logic signed [16:0] o_magnitude,
    output logic signed [15:0] o_angle
);

    logic               en;
    logic               w_valid [0:rpc_pkg::STAGES];
    rpc_pkg::t_item     w_item  [0:rpc_pkg::STAGES];

    logic               w_post_valid;
    logic signed [15:0] w_post_x;
    logic signed [15:0] w_post_y;
    logic signed [16:0] w_post_mag;
    logic signed [15:0] w_post_ang;

    logic               r_skid_full;
    logic signed [15:0] r_skid_x;
    logic signed [15:0] r_skid_y;
    logic signed [16:0] r_skid_mag;
    logic signed [15:0] r_skid_ang;

    assign en = !r_skid_full;

    rpc_pre u_pre (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (i_valid),
        .i_action         (i_action),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_valid          (w_valid[0]),
        .o_item           (w_item[0])
    );

    for (genvar g = 0; g < rpc_pkg::STAGES; g++) begin : g_iter
        rpc_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .i_iter  (rpc_pkg::t_iter'(g)),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    rpc_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (w_valid[rpc_pkg::STAGES]),
        .i_item      (w_item[rpc_pkg::STAGES]),
        .o_valid     (w_post_valid),
        .o_x_out     (w_post_x),
        .o_y_out     (w_post_y),
        .o_magnitude (w_post_mag),
        .o_angle     (w_post_ang)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (!i_stall) begin
                r_skid_full <= 1'b0;
            end
        end else if (w_post_valid && i_stall) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_full) begin
            r_skid_x   <= w_post_x;
            r_skid_y   <= w_post_y;
            r_skid_mag <= w_post_mag;
            r_skid_ang <= w_post_ang;
        end
    end

    assign o_stall     = r_skid_full;
    assign o_valid     = r_skid_full || w_post_valid;
    assign o_x_out     = r_skid_full ? r_skid_x   : w_post_x;
    assign o_y_out     = r_skid_full ? r_skid_y   : w_post_y;
    assign o_magnitude = r_skid_full ? r_skid_mag : w_post_mag;
    assign o_angle     = r_skid_full ? r_skid_ang : w_post_ang;

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(w_post_valid && i_stall))
        else $error("skid register filled without a stalled result");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && i_stall) |=> (r_skid_full && $stable(r_skid_mag)
                                      && $stable(r_skid_ang)))
        else $error("skid register lost its result under stall");

    a_pipe_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |=> ($stable(w_post_valid) && $stable(w_post_mag)))
        else $error("pipeline advanced while skid register was full");

endmodule

`default_nettype wire
